>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// b must hold whenever a holds, outside reset
`define DRD_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("assertion failed");

// b must hold in the cycle after a, outside reset
`define DRD_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("assertion failed");

// b must hold in the cycle after a, checked through reset
`define DRD_ASSERT_NXT_ALL(lbl, ck, a, b) \
  lbl: assert property (@(posedge ck) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> design/drd_pkg.sv
package drd_pkg;

  localparam int VALUE_W    = 24;
  localparam int SCORE_W    = 13;
  localparam int CLASS_W    = 7;
  localparam int COL_W      = 8;
  localparam int SCALE_W    = 16;
  localparam int THR_W      = 13;
  localparam int PROD_W     = VALUE_W + SCALE_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int SIZE_W     = 20;
  localparam int EDGE_W     = 21;
  localparam int SIZE_SHIFT = 20;
  localparam int EDGE_SHIFT = 21;
  localparam int Q12_SHIFT  = 12;

  localparam int BOX_COLS        = 4;
  localparam int OBJ_COL         = 4;
  localparam int FIRST_CLASS_COL = 5;
  localparam logic [SCORE_W-1:0] ONE_Q12 = 13'd4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE        = 2'd2;

  localparam logic [THR_W-1:0]   THR_RESET   = 13'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = CLASS_W + SCORE_W + 2 * EDGE_W + 2 * SIZE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [CLASS_W-1:0] best_class;
    logic [SCORE_W-1:0] best_score;
    logic [SCORE_W-1:0] objectness;
    logic [VALUE_W-1:0] cx;
    logic [VALUE_W-1:0] cy;
    logic [VALUE_W-1:0] w;
    logic [VALUE_W-1:0] h;
  } row_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [THR_W-1:0]   conf_threshold;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
  } cfg_t;

  function automatic logic [SCORE_W-1:0] clamp_one(input logic [VALUE_W-1:0] v);
    logic [SCORE_W-1:0] r;
    if (v > VALUE_W'(ONE_Q12)) begin
      r = ONE_Q12;
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/detection_row_decoder_top.sv
// A row record passes the queue, stage 1, stage 2 and the output register.
// Throughput: one word in, one detection out per cycle, when m_tready does not stall.
// A 4-row queue decouples word intake from the multiply/threshold pipeline;
// the input stalls only while that queue is full.
// Reset (synchronous, rst high) clears row state, queue, pipeline valids and restores
// conf_threshold=1024, x_scale=256, y_scale=256.
module detection_row_decoder_top #(
  parameter int MAX_CLASSES = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [drd_pkg::IN_TDATA_W-1:0]      s_tdata,  // [23:0] value
  input  logic                                s_tlast,  // last_in_row
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [6:0] class_id, [19:7] confidence, [40:20] box_left, [61:41] box_top,
  // [81:62] box_width, [101:82] box_height, [103:102] zero
  output logic [drd_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [drd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  drd_pkg::cfg_t      cfg;
  drd_pkg::q_status_t q_status;
  drd_pkg::row_rec_t  push_rec;
  drd_pkg::row_rec_t  head_rec;
  logic               push;
  logic               pop;

  logic [drd_pkg::CLASS_W-1:0]       class_id;
  logic [drd_pkg::SCORE_W-1:0]       confidence;
  logic signed [drd_pkg::EDGE_W-1:0] box_left;
  logic signed [drd_pkg::EDGE_W-1:0] box_top;
  logic [drd_pkg::SIZE_W-1:0]        box_width;
  logic [drd_pkg::SIZE_W-1:0]        box_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= drd_pkg::THR_RESET;
      cfg.x_scale        <= drd_pkg::SCALE_RESET;
      cfg.y_scale        <= drd_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drd_pkg::CFG_CONF_THRESHOLD: cfg.conf_threshold <= cfg_data[drd_pkg::THR_W-1:0];
        drd_pkg::CFG_X_SCALE:        cfg.x_scale        <= cfg_data;
        drd_pkg::CFG_Y_SCALE:        cfg.y_scale        <= cfg_data;
        default: ;
      endcase
    end
  end

  drd_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .value      (s_tdata[drd_pkg::VALUE_W-1:0]),
    .last_in_row(s_tlast),
    .q_status   (q_status),
    .push       (push),
    .push_rec   (push_rec)
  );

  drd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head_rec(head_rec),
    .status  (q_status)
  );

  drd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .head_rec  (head_rec),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .class_id  (class_id),
    .confidence(confidence),
    .box_left  (box_left),
    .box_top   (box_top),
    .box_width (box_width),
    .box_height(box_height)
  );

  assign m_tdata = {
    (drd_pkg::OUT_TDATA_W - drd_pkg::OUT_FIELD_W)'(0),
    box_height, box_width, box_top, box_left, confidence, class_id
  };

endmodule

>>> design/drd_queue.sv
module drd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  drd_pkg::row_rec_t  push_rec,
  input  logic               pop,
  output drd_pkg::row_rec_t  head_rec,
  output drd_pkg::q_status_t status
);

  drd_pkg::row_rec_t            entries [drd_pkg::QUEUE_DEPTH];
  logic [drd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [drd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [drd_pkg::QPTR_W:0]     count;

  assign status.full  = (count == (drd_pkg::QPTR_W + 1)'(drd_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head_rec     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/drd_front.sv
module drd_front #(
  parameter int MAX_CLASSES = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [drd_pkg::VALUE_W-1:0]   value,
  input  logic                          last_in_row,
  input  drd_pkg::q_status_t            q_status,
  output logic                          push,
  output drd_pkg::row_rec_t             push_rec
);

  localparam int ClassEnd = MAX_CLASSES + drd_pkg::FIRST_CLASS_COL;

  logic [drd_pkg::COL_W-1:0]   column_count;
  logic [drd_pkg::VALUE_W-1:0] box_values [drd_pkg::BOX_COLS];
  logic [drd_pkg::SCORE_W-1:0] objectness;
  logic [drd_pkg::SCORE_W-1:0] best_score;
  logic [drd_pkg::CLASS_W-1:0] best_class;

  logic [drd_pkg::VALUE_W-1:0] box_next [drd_pkg::BOX_COLS];
  logic [drd_pkg::SCORE_W-1:0] objectness_next;
  logic [drd_pkg::SCORE_W-1:0] best_score_next;
  logic [drd_pkg::CLASS_W-1:0] best_class_next;
  logic [drd_pkg::SCORE_W-1:0] score;
  logic                        accept;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign score    = drd_pkg::clamp_one(value);

  always_comb begin
    box_next        = box_values;
    objectness_next = objectness;
    best_score_next = best_score;
    best_class_next = best_class;
    if (column_count < drd_pkg::COL_W'(drd_pkg::BOX_COLS)) begin
      box_next[column_count[1:0]] = value;
    end else if (column_count == drd_pkg::COL_W'(drd_pkg::OBJ_COL)) begin
      objectness_next = score;
    end else if ({1'b0, column_count} < (drd_pkg::COL_W + 1)'(ClassEnd) &&
                 score > best_score) begin
      best_score_next = score;
      best_class_next = drd_pkg::CLASS_W'(column_count -
                                          drd_pkg::COL_W'(drd_pkg::FIRST_CLASS_COL));
    end
  end

  assign push                = accept && last_in_row;
  assign push_rec.best_class = best_class_next;
  assign push_rec.best_score = best_score_next;
  assign push_rec.objectness = objectness_next;
  assign push_rec.cx         = box_next[0];
  assign push_rec.cy         = box_next[1];
  assign push_rec.w          = box_next[2];
  assign push_rec.h          = box_next[3];

  always_ff @(posedge clk) begin
    if (accept) begin
      box_values <= box_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      objectness   <= '0;
      best_score   <= '0;
      best_class   <= '0;
    end else if (accept) begin
      if (last_in_row) begin
        column_count <= '0;
        objectness   <= '0;
        best_score   <= '0;
        best_class   <= '0;
      end else begin
        if (column_count != '1) begin
          column_count <= column_count + 1'b1;
        end
        objectness <= objectness_next;
        best_score <= best_score_next;
        best_class <= best_class_next;
      end
    end
  end

endmodule

>>> design/drd_back.sv
module drd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  drd_pkg::cfg_t                     cfg,
  input  drd_pkg::q_status_t                q_status,
  input  drd_pkg::row_rec_t                 head_rec,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [drd_pkg::CLASS_W-1:0]       class_id,
  output logic [drd_pkg::SCORE_W-1:0]       confidence,
  output logic signed [drd_pkg::EDGE_W-1:0] box_left,
  output logic signed [drd_pkg::EDGE_W-1:0] box_top,
  output logic [drd_pkg::SIZE_W-1:0]        box_width,
  output logic [drd_pkg::SIZE_W-1:0]        box_height
);

  localparam int PW = drd_pkg::PROD_W;
  localparam int NW = drd_pkg::NUM_W;
  localparam int CW = 2 * drd_pkg::SCORE_W;

  logic en;

  // stage 1: products
  logic                        s1_valid;
  logic [CW-1:0]               s1_conf_prod;
  logic [PW-1:0]               s1_cx_prod;
  logic [PW-1:0]               s1_w_prod;
  logic [PW-1:0]               s1_cy_prod;
  logic [PW-1:0]               s1_h_prod;
  logic [drd_pkg::CLASS_W-1:0] s1_class;
  logic [drd_pkg::SCORE_W-1:0] s1_obj;

  // stage 2: differences, threshold decision
  logic                        s2_valid;
  logic                        s2_emit;
  logic [drd_pkg::SCORE_W-1:0] s2_conf;
  logic signed [NW-1:0]        s2_num_x;
  logic signed [NW-1:0]        s2_num_y;
  logic [drd_pkg::SIZE_W-1:0]  s2_w_pix;
  logic [drd_pkg::SIZE_W-1:0]  s2_h_pix;
  logic [drd_pkg::CLASS_W-1:0] s2_class;

  logic [drd_pkg::SCORE_W-1:0] conf_c;
  logic signed [NW-1:0]        num_x_c;
  logic signed [NW-1:0]        num_y_c;
  logic signed [NW-1:0]        sum_x_c;
  logic signed [NW-1:0]        sum_y_c;
  logic signed [NW-1:0]        bias;

  assign en   = !m_tvalid || m_tready;
  assign pop  = en && !q_status.empty;
  assign bias = NW'((64'd1 << drd_pkg::EDGE_SHIFT) - 64'd1);

  assign conf_c  = s1_conf_prod[drd_pkg::Q12_SHIFT +: drd_pkg::SCORE_W];
  assign num_x_c = $signed({1'b0, s1_cx_prod, 1'b0}) - $signed({2'b00, s1_w_prod});
  assign num_y_c = $signed({1'b0, s1_cy_prod, 1'b0}) - $signed({2'b00, s1_h_prod});
  // bias negative values so the arithmetic shift truncates toward zero
  assign sum_x_c = s2_num_x + (s2_num_x[NW-1] ? bias : '0);
  assign sum_y_c = s2_num_y + (s2_num_y[NW-1] ? bias : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid <= !q_status.empty;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_conf_prod <= CW'(head_rec.objectness) * CW'(head_rec.best_score);
      s1_cx_prod   <= PW'(head_rec.cx) * PW'(cfg.x_scale);
      s1_w_prod    <= PW'(head_rec.w) * PW'(cfg.x_scale);
      s1_cy_prod   <= PW'(head_rec.cy) * PW'(cfg.y_scale);
      s1_h_prod    <= PW'(head_rec.h) * PW'(cfg.y_scale);
      s1_class     <= head_rec.best_class;
      s1_obj       <= head_rec.objectness;

      s2_emit  <= (s1_obj >= cfg.conf_threshold) && (conf_c >= cfg.conf_threshold);
      s2_conf  <= conf_c;
      s2_num_x <= num_x_c;
      s2_num_y <= num_y_c;
      s2_w_pix <= s1_w_prod[drd_pkg::SIZE_SHIFT +: drd_pkg::SIZE_W];
      s2_h_pix <= s1_h_prod[drd_pkg::SIZE_SHIFT +: drd_pkg::SIZE_W];
      s2_class <= s1_class;

      class_id   <= s2_class;
      confidence <= s2_conf;
      box_left   <= sum_x_c[drd_pkg::EDGE_SHIFT +: drd_pkg::EDGE_W];
      box_top    <= sum_y_c[drd_pkg::EDGE_SHIFT +: drd_pkg::EDGE_W];
      box_width  <= s2_w_pix;
      box_height <= s2_h_pix;
    end
  end

endmodule

>>> design/drd_checker.sv
`include "assert_macros.svh"

module drd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [drd_pkg::OUT_TDATA_W-1:0] m_tdata
);

  `DRD_ASSERT_NXT(a_hold_on_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DRD_ASSERT_IMP(a_conf_max, clk, rst, m_tvalid, m_tdata[19:7] <= 13'd4096)
  `DRD_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[103:102] == 2'b00)
  `DRD_ASSERT_NXT_ALL(a_reset_idle, clk, rst, !m_tvalid)

endmodule

bind detection_row_decoder_top drd_checker u_drd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

>>> test/detection_row_decoder_top_tb.sv
module detection_row_decoder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CLASSES = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam longint SIZE_MAX = 1048575;
  localparam longint EDGE_MAX = 1048575;
  localparam longint EDGE_MIN = -1048576;

  typedef struct packed {
    logic [drd_pkg::OUT_TDATA_W-drd_pkg::OUT_FIELD_W-1:0] pad;
    logic [drd_pkg::SIZE_W-1:0] box_height;
    logic [drd_pkg::SIZE_W-1:0] box_width;
    logic [drd_pkg::EDGE_W-1:0] box_top;
    logic [drd_pkg::EDGE_W-1:0] box_left;
    logic [drd_pkg::SCORE_W-1:0] confidence;
    logic [drd_pkg::CLASS_W-1:0] class_id;
  } detection_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [drd_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [drd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [drd_pkg::CFG_IDX_W-1:0] cfg_index = drd_pkg::CFG_CONF_THRESHOLD;
  logic [drd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  detection_row_decoder_top #(.MAX_CLASSES(MAX_CLASSES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  logic [drd_pkg::THR_W-1:0] thr_q = drd_pkg::THR_RESET;
  logic [drd_pkg::SCALE_W-1:0] xs_q = drd_pkg::SCALE_RESET;
  logic [drd_pkg::SCALE_W-1:0] ys_q = drd_pkg::SCALE_RESET;
  logic [drd_pkg::COL_W-1:0] col_cnt = '0;
  logic [drd_pkg::VALUE_W-1:0] box_val [drd_pkg::BOX_COLS];
  logic [drd_pkg::SCORE_W-1:0] obj_q = '0;
  logic [drd_pkg::SCORE_W-1:0] best_q = '0;
  logic [drd_pkg::CLASS_W-1:0] best_cls = '0;

  detection_t pending_dets[$];
  int errors = 0;
  int n_words = 0;
  int n_rows = 0;
  int n_dets = 0;
  int cycle_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;

  task automatic mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  function automatic longint edge_px(input longint c, input longint sz, input longint sc);
    longint num;
    longint r;
    num = 2 * c * sc - sz * sc;
    if (num < 0) begin
      r = -((-num) >>> drd_pkg::EDGE_SHIFT);
    end else begin
      r = num >>> drd_pkg::EDGE_SHIFT;
    end
    if (r > EDGE_MAX) r = EDGE_MAX;
    if (r < EDGE_MIN) r = EDGE_MIN;
    return r;
  endfunction

  function automatic longint size_px(input longint sz, input longint sc);
    longint r;
    r = (sz * sc) >>> drd_pkg::SIZE_SHIFT;
    return (r > SIZE_MAX) ? SIZE_MAX : r;
  endfunction

  // update shadow state for one accepted word, queue a detection if the row passes
  task automatic decode_word(input logic [drd_pkg::VALUE_W-1:0] v, input bit last);
    logic [drd_pkg::SCORE_W-1:0] s;
    int cls;
    int conf;
    detection_t d;
    s = (v >= drd_pkg::VALUE_W'(drd_pkg::ONE_Q12)) ? drd_pkg::ONE_Q12 :
                                                      v[drd_pkg::SCORE_W-1:0];
    cls = int'(col_cnt) - drd_pkg::FIRST_CLASS_COL;
    if (col_cnt < drd_pkg::BOX_COLS) begin
      box_val[col_cnt] = v;
    end else if (col_cnt == drd_pkg::OBJ_COL) begin
      obj_q = s;
    end else if (cls < MAX_CLASSES && s > best_q) begin
      best_q = s;
      best_cls = drd_pkg::CLASS_W'(cls);
    end
    if (col_cnt != '1) col_cnt++;
    n_words++;
    if (last) begin
      n_rows++;
      conf = (int'(obj_q) * int'(best_q)) >> drd_pkg::Q12_SHIFT;
      if (obj_q >= thr_q && conf >= int'(thr_q)) begin
        d = '0;
        d.class_id = best_cls;
        d.confidence = drd_pkg::SCORE_W'(conf);
        d.box_left = drd_pkg::EDGE_W'(edge_px(box_val[0], box_val[2], xs_q));
        d.box_top = drd_pkg::EDGE_W'(edge_px(box_val[1], box_val[3], ys_q));
        d.box_width = drd_pkg::SIZE_W'(size_px(box_val[2], xs_q));
        d.box_height = drd_pkg::SIZE_W'(size_px(box_val[3], ys_q));
        pending_dets = {pending_dets, d};
      end
      col_cnt = '0;
      obj_q = '0;
      best_q = '0;
      best_cls = '0;
    end
  endtask

  task automatic send_word(input logic [drd_pkg::VALUE_W-1:0] v, input bit last);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_word(v, last);
  endtask

  task automatic send_row(input logic [drd_pkg::VALUE_W-1:0] vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  // let queued rows drain so the block is idle
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int thr, input int xs, input int ys);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= drd_pkg::CFG_CONF_THRESHOLD;
    cfg_data <= drd_pkg::CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= drd_pkg::CFG_X_SCALE;
    cfg_data <= drd_pkg::CFG_DATA_W'(xs);
    @(posedge clk);
    cfg_index <= drd_pkg::CFG_Y_SCALE;
    cfg_data <= drd_pkg::CFG_DATA_W'(ys);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_q = drd_pkg::THR_W'(thr);
    xs_q = drd_pkg::SCALE_W'(xs);
    ys_q = drd_pkg::SCALE_W'(ys);
  endtask

  function automatic logic [drd_pkg::VALUE_W-1:0] pick_value(
    input int col, input logic [drd_pkg::VALUE_W-1:0] prev);
    int r;
    r = $urandom_range(99);
    if (col < drd_pkg::BOX_COLS) begin
      if (r < 50) return drd_pkg::VALUE_W'($urandom_range(0, 1 << 20));
      if (r < 75) return drd_pkg::VALUE_W'($urandom_range(0, 1 << 23));
      return drd_pkg::VALUE_W'($urandom);
    end
    if (col == drd_pkg::OBJ_COL) begin
      if (r < 70) return drd_pkg::VALUE_W'($urandom_range(2048, 4200));
      if (r < 90) return drd_pkg::VALUE_W'($urandom_range(0, 4096));
      return drd_pkg::VALUE_W'($urandom);
    end
    if (r < 10) return prev;
    if (r < 60) return drd_pkg::VALUE_W'($urandom_range(0, 4096));
    if (r < 88) return drd_pkg::VALUE_W'($urandom_range(3000, 6000));
    return drd_pkg::VALUE_W'($urandom);
  endfunction

  task automatic send_random_rows(input int n_items);
    logic [drd_pkg::VALUE_W-1:0] vals[$];
    logic [drd_pkg::VALUE_W-1:0] prev;
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 8) len = $urandom_range(1, drd_pkg::BOX_COLS);
      else if (r < 92) len = drd_pkg::FIRST_CLASS_COL + $urandom_range(1, 12);
      else if (r < 98) len = drd_pkg::FIRST_CLASS_COL + $urandom_range(110, 140);
      else len = $urandom_range(256, 280);
      vals.delete();
      prev = '0;
      for (int c = 0; c < len; c++) begin
        prev = pick_value(c, prev);
        vals = {vals, prev};
      end
      send_row(vals);
      sent += len;
    end
  endtask

  // extremes, ties, clamping, short rows and threshold misses at reset settings
  task automatic test_directed_rows();
    send_row('{24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'd4097, 24'd4096,
               24'hFFFFFF});
    send_row('{24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'd4096, 24'd2000, 24'd2000});
    send_row('{24'h123456});
    send_row('{24'd100, 24'd200, 24'd300, 24'd400, 24'd3000});
    send_row('{24'd1, 24'd2, 24'd3, 24'd4, 24'd1023, 24'd4096});
  endtask

  task automatic test_threshold_extremes();
    write_config(0, 16'hFFFF, 16'hFFFF);
    send_row('{24'hABCDEF, 24'h000001});
    send_row('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0});
    send_row('{24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'd4096, 24'd4096});
    write_config(8191, 0, 0);
    send_row('{24'd5, 24'd6, 24'd7, 24'd8, 24'hFFFFFF, 24'hFFFFFF});
    write_config(4096, 1, 65535);
    send_row('{24'd5000, 24'd6000, 24'd700, 24'd800, 24'd4096, 24'd0, 24'd4096});
  endtask

  // class 127 is the last counted column; later columns and the saturating counter
  task automatic test_long_rows();
    logic [drd_pkg::VALUE_W-1:0] vals[$];
    write_config(1024, 256, 256);
    for (int len = drd_pkg::FIRST_CLASS_COL + MAX_CLASSES + 2; len <= 300;
         len += 300 - (drd_pkg::FIRST_CLASS_COL + MAX_CLASSES + 2)) begin
      vals.delete();
      for (int c = 0; c < len; c++) begin
        if (c < drd_pkg::BOX_COLS) vals = {vals, drd_pkg::VALUE_W'(c * 4096 + 77)};
        else if (c == drd_pkg::OBJ_COL) vals = {vals, 24'd4096};
        else if (c == drd_pkg::FIRST_CLASS_COL + MAX_CLASSES - 1) vals = {vals, 24'd3000};
        else if (c >= drd_pkg::FIRST_CLASS_COL + MAX_CLASSES) vals = {vals, 24'd4096};
        else vals = {vals, drd_pkg::VALUE_W'($urandom_range(0, 2999))};
      end
      send_row(vals);
    end
  endtask

  task automatic test_random_traffic();
    send_idle = 30;
    recv_idle = 66;
    write_config(1024, 256, 256);
    send_random_rows(250);
    write_config(0, 65535, 65535);
    send_random_rows(200);
    send_idle = 66;
    recv_idle = 30;
    write_config(4096, 0, 0);
    send_random_rows(100);
    write_config(8191, $urandom_range(0, 65535), $urandom_range(0, 65535));
    send_random_rows(100);
    write_config($urandom_range(512, 2048), $urandom_range(0, 65535), $urandom_range(0, 65535));
    send_random_rows(250);
    send_idle = 0;
    recv_idle = 0;
    write_config(2048, 65535, 1);
    send_random_rows(200);
    write_config($urandom_range(0, 2500), $urandom_range(0, 65535), $urandom_range(0, 65535));
    send_random_rows(200);
  endtask

  always @(posedge clk) begin
    detection_t got;
    detection_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = detection_t'(m_tdata);
        if (pending_dets.size() == 0) begin
          mismatch("unexpected detection, class_id", got.class_id, -1);
        end else begin
          want = pending_dets.pop_front();
          n_dets++;
          if (got.class_id != want.class_id)
            mismatch("class_id", got.class_id, want.class_id);
          if (got.confidence != want.confidence)
            mismatch("confidence", got.confidence, want.confidence);
          if (got.box_left != want.box_left)
            mismatch("box_left", $signed(got.box_left), $signed(want.box_left));
          if (got.box_top != want.box_top)
            mismatch("box_top", $signed(got.box_top), $signed(want.box_top));
          if (got.box_width != want.box_width)
            mismatch("box_width", got.box_width, want.box_width);
          if (got.box_height != want.box_height)
            mismatch("box_height", got.box_height, want.box_height);
          if (got.pad != want.pad)
            mismatch("tdata pad bits", got.pad, want.pad);
        end
      end
      m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d detections outstanding",
               cycle_cnt, pending_dets.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (box_val[i]) box_val[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_rows();
    test_threshold_extremes();
    test_long_rows();
    test_random_traffic();
    settle();
    $display("covered %0d words in %0d rows, %0d detections checked, %0d mismatches",
             n_words, n_rows, n_dets, errors);
    $display("thresholds 0..8191, scales 0..65535, long and short rows, three stall mixes");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/drd_pkg.sv
design/drd_queue.sv
design/drd_front.sv
design/drd_back.sv
design/detection_row_decoder_top.sv
design/drd_checker.sv
test/detection_row_decoder_top_tb.sv
